>>> design/q4dq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// q4dq_pkg
// Shared types, codes and float helpers for the q4 dequant dot product unit.
// ----------------------------------------------------------------------------
package q4dq_pkg;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WEIGHT,
      ST_WEIGHT_RND,
      ST_PROD,
      ST_PROD_RND,
      ST_ADD,
      ST_SUM,
      ST_OUT
   } state_type;

   // datapath operations
   typedef enum logic [1:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL,
      OP_ADD
   } op_type;

   // controller to datapath commands
   typedef struct packed {
      op_type op;
      logic   mul_sel;    // 0: scale times diff, 1: weight times activation
      logic   clear_sum;
      logic   load_out;
   } cmd_type;

   localparam logic [31:0] QNAN = 32'h7FC00000;

   // binary16 to binary32, exact
   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [4:0]  e;
      logic [9:0]  m;
      logic [7:0]  e32;
      logic [9:0]  mn;
      logic [3:0]  lz;
      logic [31:0] r;
      e = h[14:10];
      m = h[9:0];
      lz = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (m[i]) lz = 4'(9 - i);
      end
      mn = m << (lz + 4'd1);
      e32 = 8'd113 - 8'(lz) - 8'd1;
      if (e == 5'd0) begin
         if (m == 10'd0) r = {h[15], 31'd0};
         else r = {h[15], e32, mn, 13'd0};
      end else if (e == 5'd31) begin
         r = {h[15], 8'hFF, m, 13'd0};
      end else begin
         r = {h[15], 8'(e) + 8'd112, m, 13'd0};
      end
      return r;
   endfunction

   // small signed integer (-15..15) to binary32, exact
   function automatic logic [31:0] int5_to_single(input logic signed [4:0] d);
      logic [3:0]  a;
      logic [1:0]  p;
      logic [22:0] f;
      logic [31:0] r;
      a = d[4] ? 4'(-d) : d[3:0];
      p = 2'd0;
      for (int i = 0; i < 4; i++) begin
         if (a[i]) p = 2'(i);
      end
      f = 23'({a, 19'd0} << (4'd4 - 4'(p)));
      r = (a == 4'd0) ? 32'd0 : {d[4], 8'd127 + 8'(p), f};
      return r;
   endfunction

endpackage : q4dq_pkg
`default_nettype wire

>>> design/q4_block_dequant_dot_product_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// q4_block_dequant_dot_product_unit
// Dequantizes 4-bit weights, multiplies by activations, accumulates a sum.
// ----------------------------------------------------------------------------
// channel  dir  fields
// req      in   tdata: weight_nibble, block_scale, activation; tlast
// rsp      out  tdata: dot_product
// csr      in   zero_point
//
// An element steps through: input transfer, scale multiply and its rounding
// stage, product multiply and its rounding stage, adder, then the sum update.
// A last element adds an output state, which waits while a previous result
// is untaken; rsp_tvalid rises the cycle after it.
// The result register holds while rsp_tready is low.
// Reset clears the sum to +0 and the zero point to 8.
// ----------------------------------------------------------------------------
module q4_block_dequant_dot_product_unit
   import q4dq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // weight_nibble, block_scale, activation, pad
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // dot_product
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_data
);

   logic [3:0] zp_ff;
   cmd_type    cmd;

   // zero point register
   always_ff @(posedge clock) begin
      if (reset) zp_ff <= 4'd8;
      else if (csr_valid) zp_ff <= csr_data;
   end
   assign csr_ready = 1'b1;

   q4dq_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_last(req_tlast), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .cmd(cmd)
   );

   q4dq_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .zero_point(zp_ff),
      .weight_nibble(req_tdata[3:0]), .block_scale(req_tdata[19:4]),
      .activation(req_tdata[51:20]), .dot_product(rsp_tdata)
   );

   logic unused_pad;
   assign unused_pad = ^req_tdata[55:52];

   // no new result while one is pending
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
   // input not taken on back to back cycles
   a_spacing: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("input too fast");
   // result data holds while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata)) else $error("data moved");

endmodule : q4_block_dequant_dot_product_unit
`default_nettype wire

>>> design/q4dq_fmul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// q4dq_fmul
// Registered binary32 multiplier, round to nearest even.
// ----------------------------------------------------------------------------
module q4dq_fmul
   import q4dq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic      [31:0] y
);

   logic [31:0] y_ff, y_in;
   logic [47:0] prod_ff;
   logic        sgn_ff, nan_ff, inf_ff, zero_ff;
   logic signed [10:0] exp_ff;

   // stage one: unpack, multiply significands
   logic [7:0]  ea, eb;
   logic [23:0] ma, mb;
   logic [4:0]  la, lb;
   always_comb begin
      ea = a[30:23];
      eb = b[30:23];
      ma = {ea != 8'd0, a[22:0]};
      mb = {eb != 8'd0, b[22:0]};
   end

   // leading zeros of subnormal significands
   always_comb begin
      la = 5'd0;
      lb = 5'd0;
      for (int i = 0; i < 24; i++) begin
         if (ma[i]) la = 5'(23 - i);
         if (mb[i]) lb = 5'(23 - i);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= (ma << la) * (mb << lb);
      sgn_ff  <= a[31] ^ b[31];
      exp_ff  <= 11'(ea == 8'd0 ? 11'sd1 : $signed({3'd0, ea}))
               + 11'(eb == 8'd0 ? 11'sd1 : $signed({3'd0, eb}))
               - 11'sd127 - $signed({6'd0, la}) - $signed({6'd0, lb});
      nan_ff  <= (ea == 8'hFF && a[22:0] != 0) || (eb == 8'hFF && b[22:0] != 0)
               || (ea == 8'hFF && mb == 24'd0) || (eb == 8'hFF && ma == 24'd0);
      inf_ff  <= ea == 8'hFF || eb == 8'hFF;
      zero_ff <= ma == 24'd0 || mb == 24'd0;
   end

   // stage two: normalize, denormalize, round
   logic [47:0] pn;
   logic signed [10:0] en;
   logic [5:0]  sh;
   logic [49:0] sx;
   logic        sticky, g, lsb;
   logic [24:0] rm;
   logic [22:0] frac;
   logic [8:0]  ef;
   always_comb begin
      if (prod_ff[47]) begin
         pn = prod_ff;
         en = exp_ff + 11'sd1;
      end else begin
         pn = prod_ff << 1;
         en = exp_ff;
      end
      // pn[47] is the leading one at exponent en
      if (en < 11'sd1) sh = (en < -11'sd30) ? 6'd31 : 6'(11'sd1 - en);
      else sh = 6'd0;
      sx = {pn, 2'b00} >> sh;
      // sx[49:26] is the kept significand, sx[25] the guard bit
      sticky = |({pn, 2'b00} & ~({50{1'b1}} << sh)) || (|sx[24:0]);
      g = sx[25];
      lsb = sx[26];
      rm = {1'b0, sx[49:26]} + 25'(g & (sticky | lsb));
      if (en < 11'sd1) ef = {8'd0, rm[23]};
      else ef = 9'(en) + 9'(rm[24]);
      frac = rm[24] ? rm[23:1] : rm[22:0];
      if (nan_ff) y_in = QNAN;
      else if (inf_ff) y_in = {sgn_ff, 8'hFF, 23'd0};
      else if (zero_ff) y_in = {sgn_ff, 31'd0};
      else if (en > 11'sd254 || ef >= 9'd255) y_in = {sgn_ff, 8'hFF, 23'd0};
      else y_in = {sgn_ff, ef[7:0], frac};
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in;
   end

   assign y = y_ff;

endmodule : q4dq_fmul
`default_nettype wire

>>> design/q4dq_fadd.sv
`default_nettype none
// ----------------------------------------------------------------------------
// q4dq_fadd
// Registered binary32 adder, round to nearest even.
// ----------------------------------------------------------------------------
module q4dq_fadd
   import q4dq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic      [31:0] y
);

   logic [31:0] y_ff, y_in;
   logic [31:0] big, sml;
   logic [7:0]  eb, es, ebe, ese;
   logic [7:0]  d;
   logic [27:0] mb, ms, msh;
   logic        st;
   logic [28:0] sum;
   logic [4:0]  lz;
   logic [28:0] nrm;
   logic signed [9:0] en;
   logic [27:0] fx;
   logic        g, stk, lsb;
   logic [24:0] rm;
   logic [8:0]  ef;
   logic        sub;

   always_comb begin
      // order operands by magnitude
      if (a[30:0] >= b[30:0]) begin
         big = a;
         sml = b;
      end else begin
         big = b;
         sml = a;
      end
      eb = big[30:23];
      es = sml[30:23];
      ebe = (eb == 8'd0) ? 8'd1 : eb;
      ese = (es == 8'd0) ? 8'd1 : es;
      mb = {1'b0, eb != 8'd0, big[22:0], 3'd0};
      ms = {1'b0, es != 8'd0, sml[22:0], 3'd0};
      d = ebe - ese;
      sub = big[31] ^ sml[31];
      // align with sticky
      msh = (d > 8'd27) ? 28'd0 : ms >> d;
      st = (d > 8'd27) ? (ms != 0) : |(ms & ~(28'hFFFFFFF << d));
      msh[0] = msh[0] | st;
      sum = sub ? {1'b0, mb} - {1'b0, msh} : {1'b0, mb} + {1'b0, msh};
      // leading one search
      lz = 5'd28;
      for (int i = 0; i < 29; i++) begin
         if (sum[i]) lz = 5'(28 - i);
      end
      // sum[26] is the hidden bit at exponent ebe; a carry lands in sum[27]
      en = $signed({2'd0, ebe}) + 10'sd2 - $signed({5'd0, lz});
      if (en < 10'sd1) begin
         // subnormal: shift so the point sits at the minimum exponent
         nrm = sum << (ebe[4:0] + 5'd1);
         en = 10'sd0;
      end else begin
         // nrm[28] is the leading bit for normal results
         nrm = sum << lz;
      end
      fx = nrm[27:0];
      lsb = nrm[5];
      g = nrm[4];
      stk = |nrm[3:0];
      rm = {1'b0, nrm[28:5]} + 25'(g & (stk | lsb));
      if (en == 10'sd0) ef = {8'd0, rm[23]};
      else ef = 9'(en) + 9'(rm[24]);
      if (es == 8'hFF || eb == 8'hFF) begin
         if ((eb == 8'hFF && big[22:0] != 0) || (es == 8'hFF && sml[22:0] != 0)
             || (es == 8'hFF && sub)) y_in = QNAN;
         else y_in = big;
      end else if (sum == 29'd0) begin
         y_in = {big[31] & sml[31], 31'd0};
      end else if (ef >= 9'd255) begin
         y_in = {big[31], 8'hFF, 23'd0};
      end else begin
         y_in = {big[31], ef[7:0], rm[24] ? rm[23:1] : rm[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in;
   end

   assign y = y_ff;

   logic unused_fx;
   assign unused_fx = ^fx;

endmodule : q4dq_fadd
`default_nettype wire

>>> design/q4dq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// q4dq_datapath
// Operand registers, shared multiplier, adder and running sum.
// ----------------------------------------------------------------------------
module q4dq_datapath
   import q4dq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   input  wire logic [3:0]  zero_point,
   input  wire logic [3:0]  weight_nibble,
   input  wire logic [15:0] block_scale,
   input  wire logic [31:0] activation,
   output logic      [31:0] dot_product
);

   logic [31:0] scale_ff, diff_ff, act_ff, sum_ff, sum_in, out_ff;
   logic [31:0] mul_a, mul_b, mul_y, add_y;

   // capture operands on input transfer, result from the settled sum
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         scale_ff <= half_to_single(block_scale);
         diff_ff  <= int5_to_single(5'({1'b0, weight_nibble}) - 5'({1'b0, zero_point}));
         act_ff   <= activation;
      end
      if (cmd.load_out) out_ff <= (sum_ff[30:23] == 8'hFF && sum_ff[22:0] != 0)
                                  ? QNAN : sum_ff;
   end

   assign mul_a = cmd.mul_sel ? mul_y : scale_ff;
   assign mul_b = cmd.mul_sel ? act_ff : diff_ff;

   q4dq_fmul u_fmul (.clock(clock), .a(mul_a), .b(mul_b), .y(mul_y));
   q4dq_fadd u_fadd (.clock(clock), .a(sum_ff), .b(mul_y), .y(add_y));

   // running sum
   always_comb begin
      sum_in = sum_ff;
      if (cmd.op == OP_ADD) sum_in = add_y;
      if (cmd.clear_sum) sum_in = 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) sum_ff <= 32'd0;
      else sum_ff <= sum_in;
   end

   assign dot_product = out_ff;

endmodule : q4dq_datapath
`default_nettype wire

>>> design/q4dq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// q4dq_ctrl
// Sequencer for one element: load, two multiplies, add, optional output.
// ----------------------------------------------------------------------------
module q4dq_ctrl
   import q4dq_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  wire logic in_last,
   output logic      in_ready,
   output logic      out_valid,
   input  wire logic out_ready,
   output cmd_type   cmd
);

   state_type state_ff, state_in;
   logic      last_ff, last_in, ov_ff, ov_in;

   // state and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
      last_ff <= last_in;
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      ov_in    = ov_ff & ~out_ready;
      in_ready = 1'b0;
      cmd      = '{op: OP_NONE, mul_sel: 1'b0, clear_sum: 1'b0, load_out: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.op   = OP_LOAD;
               last_in  = in_last;
               state_in = ST_WEIGHT;
            end
         end
         // scale times difference, then its rounding stage
         ST_WEIGHT: begin
            cmd.op   = OP_MUL;
            state_in = ST_WEIGHT_RND;
         end
         ST_WEIGHT_RND: begin
            cmd.op   = OP_MUL;
            state_in = ST_PROD;
         end
         // weight times activation, then its rounding stage
         ST_PROD: begin
            cmd.op      = OP_MUL;
            cmd.mul_sel = 1'b1;
            state_in    = ST_PROD_RND;
         end
         ST_PROD_RND: begin
            cmd.op      = OP_MUL;
            cmd.mul_sel = 1'b1;
            state_in    = ST_ADD;
         end
         // adder takes the running sum and the product
         ST_ADD: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = OP_ADD;
            state_in = last_ff ? ST_OUT : ST_IDLE;
         end
         // wait for the result register to be free
         ST_OUT: begin
            if (!ov_ff || out_ready) begin
               cmd.load_out  = 1'b1;
               cmd.clear_sum = 1'b1;
               ov_in         = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign out_valid = ov_ff;

endmodule : q4dq_ctrl
`default_nettype wire

>>> dv/q4_block_dequant_dot_product_unit_test.sv
// ----------------------------------------------------------------------------
// q4_block_dequant_dot_product_unit_test
// Streams quantized weight elements with random idling and back pressure,
// predicts each row dot product with a bit exact binary32 model kept here,
// and compares every result transfer against the oldest predicted value.
// ----------------------------------------------------------------------------
module q4_block_dequant_dot_product_unit_test;
   import q4dq_pkg::*;

   typedef struct {
      logic [3:0]  nibble;
      logic [15:0] scale;
      logic [31:0] act;
      logic        last;
   } element_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;    // weight_nibble, block_scale, activation, pad
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // dot_product
   logic        csr_valid;
   logic        csr_ready;
   logic [3:0]  csr_data;

   element_type element_q[$];
   logic [31:0] dot_q[$];
   logic [3:0]  model_zp;
   logic [31:0] model_sum;
   int          mismatches;
   int          rows_seen;
   int          elems_sent;
   bit          calm;          // no idling on either side
   bit          hold_arm;      // asks the receiver for one long hold-off
   bit          hold_seen;
   int          hold_left;

   q4_block_dequant_dot_product_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // binary32 arithmetic, round to nearest even
   // ---------------------------------------------------------------------

   // value = sig / 2^63 * 2^exp, rounded once into binary32
   function automatic logic [31:0] round_single(input logic s, input int exp,
                                                input logic [63:0] sig);
      logic [63:0] x;
      int          be;
      int          sh;
      logic [23:0] q;
      logic        g;
      logic        st;
      logic [31:0] w;
      x = sig;
      be = exp;
      if (x == 64'd0) return {s, 31'd0};
      while (!x[63]) begin
         x = x << 1;
         be--;
      end
      be = be + 127;
      if (be >= 255) return {s, 8'hFF, 23'd0};
      // subnormal range: shift down keeping a sticky bit
      if (be <= 0) begin
         sh = 1 - be;
         if (sh > 63) x = 64'd1;
         else x = (x >> sh) | 64'((x & ((64'd1 << sh) - 64'd1)) != 64'd0);
         be = 0;
      end
      q = x[63:40];
      g = x[39];
      st = |x[38:0];
      // carry out of the fraction walks into the exponent, up to infinity
      w = {1'b0, 8'(be), 23'd0} + {9'd0, q[22:0]} + 32'(g & (st | q[0]));
      return {s, w[30:0]};
   endfunction

   function automatic bit is_nan(input logic [31:0] a);
      return a[30:23] == 8'hFF && a[22:0] != 23'd0;
   endfunction

   function automatic bit is_inf(input logic [31:0] a);
      return a[30:23] == 8'hFF && a[22:0] == 23'd0;
   endfunction

   function automatic int eff_exp(input logic [31:0] a);
      return (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
   endfunction

   function automatic logic [23:0] full_sig(input logic [31:0] a);
      return {a[30:23] != 8'd0, a[22:0]};
   endfunction

   function automatic logic [31:0] single_mul(input logic [31:0] a, input logic [31:0] b);
      logic        s;
      bit          za;
      bit          zb;
      logic [63:0] p;
      s = a[31] ^ b[31];
      za = a[30:0] == 31'd0;
      zb = b[30:0] == 31'd0;
      if (is_nan(a) || is_nan(b)) return QNAN;
      if ((is_inf(a) && zb) || (is_inf(b) && za)) return QNAN;
      if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
      if (za || zb) return {s, 31'd0};
      p = 64'(full_sig(a)) * 64'(full_sig(b));
      return round_single(s, eff_exp(a) + eff_exp(b) - 253, p << 16);
   endfunction

   function automatic logic [31:0] single_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] hi;
      logic [31:0] lo;
      int          d;
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] r;
      if (is_nan(a) || is_nan(b)) return QNAN;
      if (is_inf(a) && is_inf(b) && a[31] != b[31]) return QNAN;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
      if (a[30:0] == 31'd0) return b;
      if (b[30:0] == 31'd0) return a;
      // larger magnitude first
      if (a[30:0] >= b[30:0]) begin
         hi = a;
         lo = b;
      end else begin
         hi = b;
         lo = a;
      end
      d = eff_exp(hi) - eff_exp(lo);
      x = 64'(full_sig(hi)) << 39;
      y = 64'(full_sig(lo)) << 39;
      if (d > 63) y = 64'd1;
      else if (d > 0) y = (y >> d) | 64'((y & ((64'd1 << d) - 64'd1)) != 64'd0);
      r = (hi[31] == lo[31]) ? x + y : x - y;
      if (r == 64'd0) return 32'd0;
      return round_single(hi[31], eff_exp(hi) - 126, r);
   endfunction

   function automatic logic [31:0] widen_half(input logic [15:0] h);
      logic [4:0] e;
      e = h[14:10];
      if (e == 5'd0) begin
         if (h[9:0] == 10'd0) return {h[15], 31'd0};
         return round_single(h[15], -15, 64'(h[9:0]) << 54);
      end
      if (e == 5'd31) return {h[15], 8'hFF, h[9:0], 13'd0};
      return {h[15], 8'(e) + 8'd112, h[9:0], 13'd0};
   endfunction

   // fold one element into the row sum; returns 1 with the dot product on a last element
   function automatic bit fold_element(input element_type el, output logic [31:0] dot);
      int          diff;
      logic [31:0] dfl;
      logic [31:0] weight;
      diff = int'(el.nibble) - int'(model_zp);
      if (diff == 0) dfl = 32'd0;
      else dfl = round_single(diff < 0, 4, 64'(diff < 0 ? -diff : diff) << 59);
      weight = single_mul(widen_half(el.scale), dfl);
      model_sum = single_add(model_sum, single_mul(weight, el.act));
      dot = is_nan(model_sum) ? QNAN : model_sum;
      if (!el.last) return 1'b0;
      model_sum = 32'd0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      element_type el;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (element_q.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
            el = element_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {4'd0, el.act, el.scale, el.nibble};
            req_tlast  <= el.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_seen  <= 1'b0;
         hold_left  <= 0;
      end else if (hold_arm && !hold_seen) begin
         hold_seen  <= 1'b1;
         hold_left  <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || $urandom_range(99) >= 31;
      end
   end

   // ---------------------------------------------------------------------
   // monitor: predicts on input transfers, checks result transfers
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch
      element_type el;
      logic [31:0] dot;
      logic [31:0] want;
      if (reset) begin
         model_zp  = 4'd8;
         model_sum = 32'd0;
      end else begin
         if (csr_valid && csr_ready) model_zp = csr_data;
         if (req_tvalid && req_tready) begin
            el.nibble = req_tdata[3:0];
            el.scale  = req_tdata[19:4];
            el.act    = req_tdata[51:20];
            el.last   = req_tlast;
            elems_sent++;
            if (fold_element(el, dot)) dot_q = {dot_q, dot};
         end
         if (rsp_tvalid && rsp_tready) begin
            rows_seen++;
            if (dot_q.size() == 0) begin
               mismatches++;
               $display("%0t: dot_product with none expected: actual %h", $time, rsp_tdata);
            end else begin
               want = dot_q.pop_front();
               if (rsp_tdata !== want) begin
                  mismatches++;
                  $display("%0t: dot_product expected %h actual %h", $time, want, rsp_tdata);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   function automatic logic [15:0] pick_scale();
      if ($urandom_range(99) < 75)
         return {1'($urandom), 5'($urandom_range(20, 10)), 10'($urandom)};
      return 16'($urandom);
   endfunction

   function automatic logic [31:0] pick_act();
      if ($urandom_range(99) < 75)
         return {1'($urandom), 8'($urandom_range(140, 110)), 23'($urandom)};
      return $urandom;
   endfunction

   task automatic add_element(input logic [3:0] n, input logic [15:0] s,
                              input logic [31:0] a, input logic l);
      element_type el;
      el.nibble = n;
      el.scale  = s;
      el.act    = a;
      el.last   = l;
      element_q = {element_q, el};
   endtask

   // mostly whole rows; a few rows broken off by odd lengths
   task automatic add_rows(input int count);
      int n;
      int len;
      n = 0;
      while (n < count) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(12, 1);
         for (int i = 0; i < len; i++)
            add_element(4'($urandom), pick_scale(), pick_act(), i == len - 1);
         n += len;
      end
   endtask

   // sender pause until every result has come, then a settling wait
   task automatic drain();
      while (element_q.size() != 0 || req_tvalid || dot_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_zero_point(input logic [3:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_data   = 4'd0;
      calm       = 1'b0;
      hold_arm   = 1'b0;
      mismatches = 0;
      rows_seen  = 0;
      elems_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes and special values at the reset zero point
      add_element(4'd0,  16'h3C00, 32'h3F800000, 1'b1);
      add_element(4'd15, 16'h3C00, 32'h3F800000, 1'b1);
      add_element(4'd8,  16'h7BFF, 32'h7F7FFFFF, 1'b1);   // zero difference
      add_element(4'd15, 16'h0001, 32'h00000001, 1'b0);   // subnormal scale and act
      add_element(4'd0,  16'h83FF, 32'h80000001, 1'b1);
      add_element(4'd15, 16'h7BFF, 32'h7F7FFFFF, 1'b0);   // overflow to infinity
      add_element(4'd0,  16'h7BFF, 32'h7F7FFFFF, 1'b1);   // infinity minus infinity
      add_element(4'd1,  16'h7C00, 32'h3F800000, 1'b1);   // infinite scale
      add_element(4'd1,  16'hFC00, 32'h00000000, 1'b1);   // infinity times zero
      add_element(4'd3,  16'h7E01, 32'h3F800000, 1'b1);   // nan scale with payload
      add_element(4'd3,  16'hFE00, 32'hFFFFFFFF, 1'b1);   // nan act
      add_element(4'd9,  16'h8000, 32'hFF800000, 1'b1);   // negative zero scale
      add_element(4'd9,  16'h3C00, 32'h80000000, 1'b0);   // signed zero sums
      add_element(4'd7,  16'hBC00, 32'h00000000, 1'b1);
      add_element(4'd12, 16'h3555, 32'h3EAAAAAB, 1'b0);
      add_element(4'd4,  16'h3555, 32'h3EAAAAAB, 1'b1);   // exact cancellation
      add_element(4'd10, 16'h0400, 32'h00800000, 1'b1);   // deep underflow
      drain();

      // zero point at the low extreme, then the high extreme under a long hold-off
      write_zero_point(4'd0);
      add_element(4'd15, 16'h3C00, 32'hBF800000, 1'b1);
      add_rows(150);
      drain();
      write_zero_point(4'd15);
      add_element(4'd0, 16'hBC00, 32'h3F800000, 1'b1);
      hold_arm <= 1'b1;
      add_rows(150);
      drain();

      // random zero point, then a stretch with no idling, then another random zero point
      write_zero_point(4'($urandom_range(14, 1)));
      add_rows(150);
      drain();
      write_zero_point(4'd8);
      calm = 1'b1;
      add_rows(120);
      drain();
      calm = 1'b0;
      write_zero_point(4'($urandom));
      add_rows(120);
      drain();

      $display("covered %0d elements and %0d row results over five zero point settings",
               elems_sent, rows_seen);
      $display("with special float values, a long result hold-off and an idle-free stretch");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // run limit
   initial begin
      #(12 * 400000);
      $display("Mismatches found");
      $finish;
   end

endmodule
